/* src/hssd_pkg.sv */
// Package for the hall sensor speed and direction decoder.
// Holds field widths, reset values, register indexes and the sector lookup helpers.
// No dependencies.
package hssd_pkg;

	// Fixed field widths
	localparam int CODE_W       = 3;
	localparam int SECTOR_W     = 3;
	localparam int HALL_ORDER_W = 18;
	localparam int NUM_BITS     = 32;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 32;

	// Default parameter values
	localparam int DEF_PERIOD_BITS = 18;
	localparam int DEF_SPEED_BITS  = 24;

	// Sector and commit constants
	localparam int SECTOR_COUNT = 6;
	localparam logic [1:0] COMMIT_RUN = 2'd3;

	// Hall codes that never name a sector
	localparam logic [CODE_W-1:0] CODE_ALL_LOW  = 3'd0;
	localparam logic [CODE_W-1:0] CODE_ALL_HIGH = 3'd7;

	// Sector numbers with a wrap meaning
	localparam logic [SECTOR_W-1:0] SECTOR_FIRST = 3'd1;
	localparam logic [SECTOR_W-1:0] SECTOR_LAST  = 3'd6;
	localparam logic [SECTOR_W-1:0] SECTOR_NONE  = 3'd0;

	// Direction codes
	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_REV = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HALL_ORDER    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_NUM   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NUMER   = 2'd2;

	// Register reset values: order 1,3,2,6,4,5 and (pi/3)*1e6*256
	localparam logic [HALL_ORDER_W-1:0] HALL_ORDER_RST = 18'd183449;
	localparam logic [NUM_BITS-1:0]     SPEED_NUMER_RST = 32'd268082573;

	// Map a hall code to sector 1..6 through the order (numbering reversed when rev is set),
	// 0 if not listed or if the code is all low or all high. Lowest matching index wins, so scan from the top down.
	function automatic logic [SECTOR_W-1:0] code_to_sector(
		input logic [CODE_W-1:0]       code,
		input logic [HALL_ORDER_W-1:0] order,
		input logic                    rev
	);
		logic [SECTOR_W-1:0] sec;
		sec = SECTOR_NONE;
		for (int i = SECTOR_COUNT - 1; i >= 0; i--) begin
			if (order[CODE_W*i +: CODE_W] == code) begin
				sec = rev ? SECTOR_W'(SECTOR_COUNT - i) : SECTOR_W'(i + 1);
			end
		end
		if (code == CODE_ALL_LOW || code == CODE_ALL_HIGH) begin
			sec = SECTOR_NONE;
		end
		return sec;
	endfunction

	// Raw direction from previous and current sector; 6->1 wraps forward, 1->6 reverse
	function automatic logic raw_direction(
		input logic [SECTOR_W-1:0] cur,
		input logic [SECTOR_W-1:0] prev
	);
		logic dir;
		if (prev == SECTOR_LAST && cur == SECTOR_FIRST) begin
			dir = DIR_FWD;
		end else if (prev == SECTOR_FIRST && cur == SECTOR_LAST) begin
			dir = DIR_REV;
		end else begin
			dir = (cur > prev) ? DIR_FWD : DIR_REV;
		end
		return dir;
	endfunction

endpackage

/* src/hall_sensor_speed_direction_decoder.sv */
// Hall sensor speed and direction decoder: sector lookup, direction commit, speed filter.
// Uses hssd_pkg for widths, constants and the sector lookup functions.
//
// A capture transfer runs the restoring divider after acceptance (one serial divider
// step per cycle, NUM_BITS steps), then the finish step; a timeout tick goes straight to finish.
// The finish step waits while the output register is full. The input is taken again
// once the result is in the output register. arst_n clears the control and decoder
// state and loads the configuration registers with their defaults.
module hall_sensor_speed_direction_decoder #(
	parameter int PERIOD_BITS = hssd_pkg::DEF_PERIOD_BITS,
	parameter int SPEED_BITS  = hssd_pkg::DEF_SPEED_BITS,
	localparam int IN_DATA_W  = ((hssd_pkg::CODE_W + PERIOD_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((hssd_pkg::SECTOR_W + SPEED_BITS + 1 + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [IN_DATA_W-1:0]               s_axis_tdata,  // hall_code, period
	input  logic                               s_axis_tuser,  // mode
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [OUT_DATA_W-1:0]              m_axis_tdata,  // sector, signed_speed, direction
	output logic                               m_axis_tuser,  // timed_out
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hssd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [hssd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int MAG_W = SPEED_BITS - 1;
	localparam int CNT_W = $clog2(hssd_pkg::NUM_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hssd_pkg::NUM_BITS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// control state
	logic [1:0]                          state_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                tout_q;
	logic                                out_valid_q;
	// configuration
	logic [hssd_pkg::HALL_ORDER_W-1:0]   hall_order_q;
	logic                                rev_num_q;
	logic [hssd_pkg::NUM_BITS-1:0]       numer_q;
	// decoder state
	logic [hssd_pkg::CODE_W-1:0]         prev_code_q;
	logic                                prev_raw_q;
	logic [1:0]                          agree_q;
	logic                                dir_q;
	logic [MAG_W-1:0]                    filt_q;
	logic [hssd_pkg::SECTOR_W-1:0]       last_sector_q;
	// item and divider registers
	logic [hssd_pkg::CODE_W-1:0]         code_q;
	logic [PERIOD_BITS-1:0]              period_q;
	logic [hssd_pkg::NUM_BITS-1:0]       quo_q;
	logic [PERIOD_BITS-1:0]              rem_q;
	// output payload
	logic [hssd_pkg::SECTOR_W-1:0]       o_sector_q;
	logic [SPEED_BITS-1:0]               o_speed_q;
	logic                                o_dir_q;
	logic                                o_tout_q;

	logic                                in_xfer;
	logic                                out_free;
	logic [PERIOD_BITS:0]                rem_sh;
	logic [PERIOD_BITS:0]                per_ext;
	logic [PERIOD_BITS:0]                rem_diff;
	logic                                q_bit;
	logic [MAG_W-1:0]                    raw_mag;
	logic [MAG_W:0]                      filt_sum;
	logic [MAG_W-1:0]                    filt_nx;
	logic [hssd_pkg::SECTOR_W-1:0]       sec_cur;
	logic [hssd_pkg::SECTOR_W-1:0]       sec_prev;
	logic                                dir_raw;
	logic [1:0]                          agree_inc;
	logic [1:0]                          agree_nx;
	logic                                dir_nx;
	logic [SPEED_BITS-1:0]               speed_nx;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	// one restoring division step; a zero period yields all ones, which saturates
	always_comb begin
		rem_sh   = {rem_q, quo_q[hssd_pkg::NUM_BITS-1]};
		per_ext  = {1'b0, period_q};
		q_bit    = (rem_sh >= per_ext);
		rem_diff = q_bit ? (rem_sh - per_ext) : rem_sh;
	end

	// finish: saturate, filter, sector and direction commit
	always_comb begin
		if (quo_q[hssd_pkg::NUM_BITS-1:MAG_W] != '0) begin
			raw_mag = '1;
		end else begin
			raw_mag = quo_q[MAG_W-1:0];
		end
		filt_sum = {1'b0, raw_mag} + {1'b0, filt_q};
		filt_nx  = filt_sum[MAG_W:1];

		sec_cur  = hssd_pkg::code_to_sector(code_q, hall_order_q, rev_num_q);
		sec_prev = hssd_pkg::code_to_sector(prev_code_q, hall_order_q, rev_num_q);
		dir_raw  = hssd_pkg::raw_direction(sec_cur, sec_prev);

		agree_inc = agree_q + 2'd1;
		agree_nx  = 2'd0;
		dir_nx    = dir_q;
		if (dir_raw == prev_raw_q) begin
			if (agree_inc == hssd_pkg::COMMIT_RUN) begin
				dir_nx = dir_raw;
			end else begin
				agree_nx = agree_inc;
			end
		end

		if (dir_nx == hssd_pkg::DIR_REV) begin
			speed_nx = SPEED_BITS'(-{1'b0, filt_nx});
		end else begin
			speed_nx = {1'b0, filt_nx};
		end
	end

	// sequencer, configuration and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			tout_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			hall_order_q  <= hssd_pkg::HALL_ORDER_RST;
			rev_num_q     <= 1'b0;
			numer_q       <= hssd_pkg::SPEED_NUMER_RST;
			prev_code_q   <= '0;
			prev_raw_q    <= hssd_pkg::DIR_FWD;
			agree_q       <= '0;
			dir_q         <= hssd_pkg::DIR_FWD;
			filt_q        <= '0;
			last_sector_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					hssd_pkg::REG_HALL_ORDER:  hall_order_q <= cfg_data[hssd_pkg::HALL_ORDER_W-1:0];
					hssd_pkg::REG_REVERSE_NUM: rev_num_q    <= cfg_data[0];
					hssd_pkg::REG_SPEED_NUMER: numer_q      <= cfg_data;
					default: ;
				endcase
			end

			// output register: loaded by the finish step, else drained on ready
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						tout_q  <= s_axis_tuser;
						cnt_q   <= '0;
						state_q <= s_axis_tuser ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						if (!tout_q) begin
							prev_code_q   <= code_q;
							prev_raw_q    <= dir_raw;
							agree_q       <= agree_nx;
							dir_q         <= dir_nx;
							filt_q        <= filt_nx;
							last_sector_q <= sec_cur;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, divider datapath and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_q   <= s_axis_tdata[hssd_pkg::CODE_W-1:0];
			period_q <= s_axis_tdata[hssd_pkg::CODE_W +: PERIOD_BITS];
			quo_q    <= numer_q;
			rem_q    <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[hssd_pkg::NUM_BITS-2:0], q_bit};
			rem_q <= rem_diff[PERIOD_BITS-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			o_tout_q <= tout_q;
			if (tout_q) begin
				o_sector_q <= last_sector_q;
				o_speed_q  <= '0;
				o_dir_q    <= dir_q;
			end else begin
				o_sector_q <= sec_cur;
				o_speed_q  <= speed_nx;
				o_dir_q    <= dir_nx;
			end
		end
	end

	// result packing
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[hssd_pkg::SECTOR_W-1:0]                  = o_sector_q;
		m_axis_tdata[hssd_pkg::SECTOR_W +: SPEED_BITS]        = o_speed_q;
		m_axis_tdata[hssd_pkg::SECTOR_W + SPEED_BITS]         = o_dir_q;
	end
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = o_tout_q;

	// checks
	a_agree_range: assert property (@(posedge clk) disable iff (!arst_n)
		agree_q != 2'd3)
		else $error("agree count reached commit run without reset");

	a_capture_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !s_axis_tuser) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("capture did not start the divider");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q != CNT_LAST) |=>
		(state_q == ST_DIV && cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("divider step count broke");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result appeared outside finish step");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (o_speed_q == '0))
		else $error("timeout result carries nonzero speed");

endmodule
